@@ rtl/dsq_pkg.sv @@
// dsq_pkg: shared types and constants for the delta sleep queue.
// Item field widths, action and status codes, parameter defaults.
// No dependencies.
`default_nettype none

package dsq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_TIME_BITS   = 16;
   localparam int DEF_ID_BITS     = 8;

   localparam int ACTION_W = 2;
   localparam int TID_W    = 8;
   localparam int TICKS_W  = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TID_W-1:0]    thread_id;
      logic [TICKS_W-1:0]  sleep_ticks;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                woke;
      logic [TID_W-1:0]    woken_id;
      logic [COUNT_W-1:0]  entry_count;
      logic                last;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/dsq_req_if.sv @@
// dsq_req_if: request channel of the delta sleep queue, valid/ready handshake.
// Depends on dsq_pkg for the item type.
`default_nettype none

interface dsq_req_if;
   logic                 valid;
   logic                 ready;
   dsq_pkg::req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ rtl/dsq_rsp_if.sv @@
// dsq_rsp_if: response channel of the delta sleep queue, valid/ready handshake.
// Depends on dsq_pkg for the item type.
`default_nettype none

interface dsq_rsp_if;
   logic                 valid;
   logic                 ready;
   dsq_pkg::rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ rtl/dsq_alu.sv @@
// dsq_alu: shared add/subtract unit for delta arithmetic and compares.
// Standalone; no package use.
`default_nettype none

module dsq_alu #(
   parameter int W = 16
) (
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   input  wire logic         sub,
   output logic [W-1:0]      res,
   output logic              borrow
);

   logic [W-1:0] b_op;
   logic [W:0]   sum;

   assign b_op   = sub ? ~b : b;
   assign sum    = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, sub};
   assign res    = sum[W-1:0];
   assign borrow = sub & ~sum[W];

endmodule

`default_nettype wire

@@ rtl/dsq_store.sv @@
// dsq_store: slot memory of the sleep queue, one write and one registered read.
// Standalone; no package use.
`default_nettype none

module dsq_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 24
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0]      rd_data_ff
);

   logic [DATA_W-1:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/delta_sleep_queue.sv @@
// delta_sleep_queue: sleep queue of threads kept as an ordered delta list.
// Uses dsq_pkg, dsq_req_if, dsq_rsp_if, dsq_store and dsq_alu.
//
// Usage:
//   req carries one item: action (add, tick, remove), thread_id, sleep_ticks.
//   rsp returns the results of that item: status, woke, woken_id,
//   entry_count and last; last marks the final result of an item.
//   Add and remove give one result. A tick gives one result per released
//   thread, or one result with woke low when nothing wakes.
//   req.ready is high only while the sequencer is idle; one item is worked
//   at a time. Steps from accept to result:
//     add    respond directly if rejected; else scan, shift entries up, write
//     remove scan for the thread, shift later entries down if found
//     tick   respond directly on an empty queue; else decrement the head,
//            then for each released thread shift the queue down and report it
//   The slot memory read is registered, so a slot visit is a read state
//   then an evaluate or write state; the shared adder does every delta update.
//   Reset empties the queue at once; slot contents are not cleared.
//   A stalled rsp holds the result; the sequencer waits until it is taken.
`default_nettype none

module delta_sleep_queue #(
   parameter int QUEUE_DEPTH = dsq_pkg::DEF_QUEUE_DEPTH,
   parameter int TIME_BITS   = dsq_pkg::DEF_TIME_BITS,
   parameter int ID_BITS     = dsq_pkg::DEF_ID_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   dsq_req_if.sink   req,
   dsq_rsp_if.source rsp
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ENT_W = ID_BITS + TIME_BITS;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_RESP     = 4'd1;
   localparam logic [3:0] S_ASCAN_RD = 4'd2;
   localparam logic [3:0] S_ASCAN_EV = 4'd3;
   localparam logic [3:0] S_ASH_RD   = 4'd4;
   localparam logic [3:0] S_ASH_WR   = 4'd5;
   localparam logic [3:0] S_APUT     = 4'd6;
   localparam logic [3:0] S_RSCAN_RD = 4'd7;
   localparam logic [3:0] S_RSCAN_EV = 4'd8;
   localparam logic [3:0] S_SH_RD    = 4'd9;
   localparam logic [3:0] S_SH_WR    = 4'd10;
   localparam logic [3:0] S_TDEC_RD  = 4'd11;
   localparam logic [3:0] S_TDEC_EV  = 4'd12;
   localparam logic [3:0] S_TCHK_RD  = 4'd13;
   localparam logic [3:0] S_TCHK_EV  = 4'd14;

   logic [3:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [CNT_W-1:0]                idx_ff, idx_in;
   logic [CNT_W-1:0]                ptr_ff, ptr_in;
   logic [TIME_BITS-1:0]            rem_ff, rem_in;
   logic [ID_BITS-1:0]              id_ff, id_in;
   logic [dsq_pkg::ACTION_W-1:0]    act_ff, act_in;
   logic [dsq_pkg::STATUS_W-1:0]    pend_ff, pend_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   dsq_pkg::rsp_item_type           rsp_item_ff, rsp_item_in;

   logic                            mem_rd_en, mem_wr_en;
   logic [CNT_W-1:0]                rd_full, wr_full;
   logic [ENT_W-1:0]                mem_rd_data, mem_wr_data;
   logic [ID_BITS-1:0]              rd_id;
   logic [TIME_BITS-1:0]            rd_delta;

   logic [TIME_BITS-1:0]            alu_a, alu_b, alu_res;
   logic                            alu_sub, alu_borrow;

   logic [ID_BITS+dsq_pkg::TID_W-1:0]       in_id_ext;
   logic [TIME_BITS+dsq_pkg::TICKS_W-1:0]   in_time_ext;
   logic [ID_BITS-1:0]                      in_id;
   logic [TIME_BITS-1:0]                    in_time;
   logic [ID_BITS+dsq_pkg::TID_W-1:0]       out_id_ext;
   logic [CNT_W+dsq_pkg::COUNT_W-1:0]       out_cnt_ext;
   logic                                    out_free;
   logic                                    fold_here;

   assign in_id_ext   = {{ID_BITS{1'b0}}, req.item.thread_id};
   assign in_time_ext = {{TIME_BITS{1'b0}}, req.item.sleep_ticks};
   assign in_id       = in_id_ext[ID_BITS-1:0];
   assign in_time     = in_time_ext[TIME_BITS-1:0];
   assign out_id_ext  = {{dsq_pkg::TID_W{1'b0}}, id_ff};
   assign out_cnt_ext = {{dsq_pkg::COUNT_W{1'b0}}, cnt_ff};

   assign rd_id     = mem_rd_data[ENT_W-1:TIME_BITS];
   assign rd_delta  = mem_rd_data[TIME_BITS-1:0];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign fold_here = (ptr_ff == idx_ff + CNT_W'(1));

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.item  = rsp_item_ff;

   dsq_store #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (IDX_W),
      .DATA_W (ENT_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (wr_full[IDX_W-1:0]),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (rd_full[IDX_W-1:0]),
      .rd_data_ff (mem_rd_data)
   );

   dsq_alu #(
      .W (TIME_BITS)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   always_comb begin
      alu_a   = rem_ff;
      alu_b   = rd_delta;
      alu_sub = 1'b1;
      unique case (state_ff)
         S_ASH_WR: begin
            alu_a = rd_delta;
            alu_b = rem_ff;
         end
         S_SH_WR: begin
            alu_a   = rd_delta;
            alu_b   = rem_ff;
            alu_sub = 1'b0;
         end
         S_TDEC_EV: begin
            alu_a = rd_delta;
            alu_b = TIME_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      id_in        = id_ff;
      act_in       = act_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_item_in  = rsp_item_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      rd_full      = idx_ff;
      wr_full      = ptr_ff;
      mem_wr_data  = {rd_id, rd_delta};

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               act_in  = req.item.action;
               id_in   = in_id;
               rem_in  = in_time;
               idx_in  = '0;
               pend_in = dsq_pkg::ST_OK;
               unique case (req.item.action)
                  dsq_pkg::ACT_ADD: begin
                     if (in_time == '0) begin
                        pend_in  = dsq_pkg::ST_ZERO;
                        state_in = S_RESP;
                     end else if (cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                        pend_in  = dsq_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_ASCAN_RD;
                     end
                  end
                  dsq_pkg::ACT_TICK: begin
                     state_in = (cnt_ff == '0) ? S_RESP : S_TDEC_RD;
                  end
                  dsq_pkg::ACT_REMOVE: begin
                     state_in = S_RSCAN_RD;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = pend_ff;
               rsp_item_in.woke         = 1'b0;
               rsp_item_in.woken_id     = '0;
               rsp_item_in.entry_count  = out_cnt_ext[dsq_pkg::COUNT_W-1:0];
               rsp_item_in.last         = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         S_ASCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               ptr_in   = cnt_ff;
               state_in = S_ASH_RD;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_ASCAN_EV;
            end
         end
         S_ASCAN_EV: begin
            if (!alu_borrow && alu_res != '0) begin
               rem_in   = alu_res;
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_ASCAN_RD;
            end else begin
               ptr_in   = cnt_ff;
               state_in = S_ASH_RD;
            end
         end
         S_ASH_RD: begin
            if (ptr_ff == idx_ff) begin
               state_in = S_APUT;
            end else begin
               mem_rd_en = 1'b1;
               rd_full   = ptr_ff - CNT_W'(1);
               state_in  = S_ASH_WR;
            end
         end
         S_ASH_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {rd_id, fold_here ? alu_res : rd_delta};
            ptr_in      = ptr_ff - CNT_W'(1);
            state_in    = S_ASH_RD;
         end
         S_APUT: begin
            mem_wr_en   = 1'b1;
            wr_full     = idx_ff;
            mem_wr_data = {id_ff, rem_ff};
            cnt_in      = cnt_ff + CNT_W'(1);
            state_in    = S_RESP;
         end
         S_RSCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               pend_in  = dsq_pkg::ST_NOTFOUND;
               state_in = S_RESP;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_RSCAN_EV;
            end
         end
         S_RSCAN_EV: begin
            if (rd_id == id_ff) begin
               rem_in   = rd_delta;
               ptr_in   = idx_ff + CNT_W'(1);
               state_in = S_SH_RD;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_RSCAN_RD;
            end
         end
         S_SH_RD: begin
            if (ptr_ff == cnt_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = (act_ff == dsq_pkg::ACT_TICK) ? S_TCHK_RD : S_RESP;
            end else begin
               mem_rd_en = 1'b1;
               rd_full   = ptr_ff;
               state_in  = S_SH_WR;
            end
         end
         S_SH_WR: begin
            mem_wr_en   = 1'b1;
            wr_full     = ptr_ff - CNT_W'(1);
            mem_wr_data = {rd_id, fold_here ? alu_res : rd_delta};
            ptr_in      = ptr_ff + CNT_W'(1);
            state_in    = S_SH_RD;
         end
         S_TDEC_RD: begin
            mem_rd_en = 1'b1;
            rd_full   = '0;
            state_in  = S_TDEC_EV;
         end
         S_TDEC_EV: begin
            if (rd_delta == '0 || alu_res == '0) begin
               id_in    = rd_id;
               idx_in   = '0;
               rem_in   = '0;
               ptr_in   = CNT_W'(1);
               state_in = S_SH_RD;
            end else begin
               mem_wr_en   = 1'b1;
               wr_full     = '0;
               mem_wr_data = {rd_id, alu_res};
               state_in    = S_RESP;
            end
         end
         S_TCHK_RD: begin
            if (cnt_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in            = 1'b1;
                  rsp_item_in.status      = dsq_pkg::ST_OK;
                  rsp_item_in.woke        = 1'b1;
                  rsp_item_in.woken_id    = out_id_ext[dsq_pkg::TID_W-1:0];
                  rsp_item_in.entry_count = out_cnt_ext[dsq_pkg::COUNT_W-1:0];
                  rsp_item_in.last        = 1'b1;
                  state_in                = S_IDLE;
               end
            end else begin
               mem_rd_en = 1'b1;
               rd_full   = '0;
               state_in  = S_TCHK_EV;
            end
         end
         S_TCHK_EV: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.status      = dsq_pkg::ST_OK;
               rsp_item_in.woke        = 1'b1;
               rsp_item_in.woken_id    = out_id_ext[dsq_pkg::TID_W-1:0];
               rsp_item_in.entry_count = out_cnt_ext[dsq_pkg::COUNT_W-1:0];
               rsp_item_in.last        = (rd_delta != '0);
               if (rd_delta == '0) begin
                  id_in    = rd_id;
                  idx_in   = '0;
                  rem_in   = '0;
                  ptr_in   = CNT_W'(1);
                  state_in = S_SH_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      rem_ff      <= rem_in;
      id_ff       <= id_in;
      act_ff      <= act_in;
      pend_ff     <= pend_in;
      rsp_item_ff <= rsp_item_in;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (wr_full < CNT_W'(QUEUE_DEPTH)))
      else $error("slot write outside queue");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("slot read and write in one cycle");

   a_more_is_wake: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.last) |-> rsp_item_ff.woke)
      else $error("non-final item without a woken thread");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("item accepted while sequencer still busy");
`endif

endmodule

`default_nettype wire
